/* src/ssc_pkg.sv */
// Shared constants for the sphere-sphere contact point pipeline.
`timescale 1ns / 1ps

package ssc_pkg;

    // Default coordinate width, signed fixed point.
    localparam int COORD_BITS_DEF = 32;

    // Lane numbering of the six point offsets: first sphere x, y, z then second.
    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 6;

endpackage

/* src/sphere_sphere_contact_points_top.sv */
// Top level of the sphere-sphere contact point pipeline.
//
//  Channel   Handshake        Payload
//  request   start / busy     centre_a xyz, radius_a, centre_b xyz, radius_b
//  result    done (strobe)    hit, degenerate, contact_a xyz, contact_b xyz
//
// One request may enter every cycle; busy is always low.
// The pipeline has three front stages, a COORD_BITS+2 stage square root, two
// stages for products and divisor set-up, a COORD_BITS-1 stage divider and the
// output register.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The receiver cannot stall, so each result shows for one cycle with done high.
`timescale 1ns / 1ps

module sphere_sphere_contact_points_top #(
    parameter int COORD_BITS = ssc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] center_a_x,
    input  logic signed [COORD_BITS-1:0] center_a_y,
    input  logic signed [COORD_BITS-1:0] center_a_z,
    input  logic        [COORD_BITS-2:0] radius_a,
    input  logic signed [COORD_BITS-1:0] center_b_x,
    input  logic signed [COORD_BITS-1:0] center_b_y,
    input  logic signed [COORD_BITS-1:0] center_b_z,
    input  logic        [COORD_BITS-2:0] radius_b,
    output logic                         done,
    output logic                         hit,
    output logic                         degenerate,
    output logic signed [COORD_BITS-1:0] contact_a_x,
    output logic signed [COORD_BITS-1:0] contact_a_y,
    output logic signed [COORD_BITS-1:0] contact_a_z,
    output logic signed [COORD_BITS-1:0] contact_b_x,
    output logic signed [COORD_BITS-1:0] contact_b_y,
    output logic signed [COORD_BITS-1:0] contact_b_z
);

    localparam int C   = COORD_BITS;
    localparam int NA  = ssc_pkg::NUM_AXES;
    localparam int NL  = ssc_pkg::NUM_LANES;
    localparam int MW  = C + 1;          // magnitude of a centre difference
    localparam int LW  = C + 2;          // length of the difference vector
    localparam int SW  = 2 * LW;         // squared length
    localparam int PW  = 2 * C;          // magnitude times radius
    localparam int NW  = 2 * C + 2;      // rounded numerator
    localparam int DNW = C + 3;          // twice the length
    localparam int QW  = C - 1;          // offset, never above the radius
    localparam int SDW = 2 * NA * C + NA + NA * MW + 2 * (C - 1) + 2;
    localparam int TDW = 2 * NA * C + NA + 2;

    // The pipeline never holds requests off.
    assign busy = 1'b0;

    // Stage 1: centre differences.
    logic                v1_reg;
    logic signed [C-1:0] a1_reg [NA];
    logic signed [C-1:0] b1_reg [NA];
    logic signed [C:0]   d1_reg [NA];
    logic [C-2:0]        ra1_reg, rb1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg[0] <= center_a_x;
        a1_reg[1] <= center_a_y;
        a1_reg[2] <= center_a_z;
        b1_reg[0] <= center_b_x;
        b1_reg[1] <= center_b_y;
        b1_reg[2] <= center_b_z;
        d1_reg[0] <= (C+1)'(center_b_x) - (C+1)'(center_a_x);
        d1_reg[1] <= (C+1)'(center_b_y) - (C+1)'(center_a_y);
        d1_reg[2] <= (C+1)'(center_b_z) - (C+1)'(center_a_z);
        ra1_reg   <= radius_a;
        rb1_reg   <= radius_b;
    end

    // Stage 2: squares of the differences and of the radius sum.
    logic                v2_reg;
    logic signed [C-1:0] a2_reg [NA];
    logic signed [C-1:0] b2_reg [NA];
    logic [MW-1:0]       mag2_reg [NA];
    logic [NA-1:0]       neg2_reg;
    logic [2*MW-1:0]     sq2_reg [NA];
    logic [PW-1:0]       rr2_reg;
    logic [C-2:0]        ra2_reg, rb2_reg;
    logic [MW-1:0]       mag1 [NA];
    logic [C-1:0]        rsum1;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            mag1[i] = d1_reg[i][C] ? MW'(-d1_reg[i]) : MW'(d1_reg[i]);
        end
        rsum1 = {1'b0, ra1_reg} + {1'b0, rb1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            a2_reg[i]   <= a1_reg[i];
            b2_reg[i]   <= b1_reg[i];
            mag2_reg[i] <= mag1[i];
            neg2_reg[i] <= d1_reg[i][C];
            sq2_reg[i]  <= (2*MW)'(mag1[i]) * (2*MW)'(mag1[i]);
        end
        rr2_reg <= PW'(rsum1) * PW'(rsum1);
        ra2_reg <= ra1_reg;
        rb2_reg <= rb1_reg;
    end

    // Stage 3: squared length, contact test and coincidence test.
    logic            v3_reg;
    logic [SW-1:0]   s3_reg;
    logic [SDW-1:0]  side3_reg;
    logic [SW-1:0]   s2_sum;

    assign s2_sum = SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg    <= s2_sum;
        side3_reg <= {a2_reg[0], a2_reg[1], a2_reg[2], b2_reg[0], b2_reg[1], b2_reg[2],
                      neg2_reg, mag2_reg[0], mag2_reg[1], mag2_reg[2], ra2_reg, rb2_reg,
                      (s2_sum <= SW'(rr2_reg)), (s2_sum == '0)};
    end

    // Square root, with the side data delayed to match.
    logic [LW-1:0]  len_root;
    logic           vq_reg   [LW];
    logic [SDW-1:0] sideq_reg [LW];

    ssc_isqrt #(
        .LW (LW)
    ) u_isqrt (
        .clk      (clk),
        .radicand (s3_reg),
        .root     (len_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LW; i++)
            begin
                vq_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vq_reg[0] <= v3_reg;
            for (int i = 1; i < LW; i++)
            begin
                vq_reg[i] <= vq_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sideq_reg[0] <= side3_reg;
        for (int i = 1; i < LW; i++)
        begin
            sideq_reg[i] <= sideq_reg[i-1];
        end
    end

    // Unpack the side data at the root output.
    logic [NA*C-1:0]    aq_flat, bq_flat;
    logic [NA-1:0]      negq;
    logic [NA*MW-1:0]   magq_flat;
    logic [C-2:0]       raq, rbq;
    logic               hitq, degq;

    assign {aq_flat, bq_flat, negq, magq_flat, raq, rbq, hitq, degq} = sideq_reg[LW-1];

    // Stage P: magnitude times radius for each of the six offsets.
    logic            vp_reg;
    logic [PW-1:0]   prod_reg [NL];
    logic [LW-1:0]   lenp_reg;
    logic [TDW-1:0]  tailp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= vq_reg[LW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            prod_reg[i]      <= PW'(magq_flat[(NA-1-i)*MW +: MW]) * PW'(raq);
            prod_reg[i + NA] <= PW'(magq_flat[(NA-1-i)*MW +: MW]) * PW'(rbq);
        end
        lenp_reg  <= len_root;
        tailp_reg <= {aq_flat, bq_flat, negq, hitq, degq};
    end

    // Stage N: numerator 2*m*r + L and divisor 2*L for rounding to nearest.
    logic            vn_reg;
    logic [NW-1:0]   num_reg [NL];
    logic [DNW-1:0]  den_reg;
    logic [TDW-1:0]  tailn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
        end
        else
        begin
            vn_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NL; i++)
        begin
            num_reg[i] <= {prod_reg[i], 1'b0} + NW'(lenp_reg);
        end
        den_reg   <= {lenp_reg, 1'b0};
        tailn_reg <= tailp_reg;
    end

    // Six divider lanes, with the tail data delayed to match.
    logic [QW-1:0]  quot [NL];
    logic           vd_reg    [QW];
    logic [TDW-1:0] taild_reg [QW];

    for (genvar k = 0; k < NL; k++) begin : g_lane
        ssc_div #(
            .NW (NW),
            .DW (DNW),
            .QW (QW)
        ) u_div (
            .clk  (clk),
            .num  (num_reg[k]),
            .den  (den_reg),
            .quot (quot[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vd_reg[0] <= vn_reg;
            for (int i = 1; i < QW; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        taild_reg[0] <= tailn_reg;
        for (int i = 1; i < QW; i++)
        begin
            taild_reg[i] <= taild_reg[i-1];
        end
    end

    // Output stage: apply signs, add to the centres and saturate; a miss gives zeros, a coincident pair the centres.
    logic [NA*C-1:0]     ad_flat, bd_flat;
    logic [NA-1:0]       negd;
    logic                hitd, degd;
    logic signed [C-1:0] pt_next [NL];

    assign {ad_flat, bd_flat, negd, hitd, degd} = taild_reg[QW-1];

    function automatic logic signed [C-1:0] sat_coord(input logic signed [C:0] v);
        logic signed [C-1:0] res;
        res = v[C-1:0];
        if (v[C] != v[C-1])
        begin
            res = v[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            logic signed [C:0] ca, cb, oa, ob;
            ca = (C+1)'(signed'(ad_flat[(NA-1-i)*C +: C]));
            cb = (C+1)'(signed'(bd_flat[(NA-1-i)*C +: C]));
            oa = signed'((C+1)'(quot[i]));
            ob = signed'((C+1)'(quot[i + NA]));
            if (!hitd)
            begin
                pt_next[i]      = '0;
                pt_next[i + NA] = '0;
            end
            else if (degd)
            begin
                pt_next[i]      = ca[C-1:0];
                pt_next[i + NA] = cb[C-1:0];
            end
            else
            begin
                pt_next[i]      = sat_coord(negd[i] ? (ca - oa) : (ca + oa));
                pt_next[i + NA] = sat_coord(negd[i] ? (cb + ob) : (cb - ob));
            end
        end
    end

    logic                done_reg, hit_reg, deg_reg;
    logic signed [C-1:0] pt_reg [NL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hitd;
        deg_reg <= hitd & degd;
        for (int i = 0; i < NL; i++)
        begin
            pt_reg[i] <= pt_next[i];
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign degenerate  = deg_reg;
    assign contact_a_x = pt_reg[0];
    assign contact_a_y = pt_reg[1];
    assign contact_a_z = pt_reg[2];
    assign contact_b_x = pt_reg[3];
    assign contact_b_y = pt_reg[4];
    assign contact_b_z = pt_reg[5];

endmodule

/* src/ssc_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module ssc_isqrt #(
    parameter int LW = ssc_pkg::COORD_BITS_DEF + 2
) (
    input  logic              clk,
    input  logic [2*LW-1:0]   radicand,
    output logic [LW-1:0]     root
);

    localparam int RW = LW + 2;

    logic [RW-1:0]   rem_reg  [LW+1];
    logic [LW-1:0]   root_reg [LW+1];
    logic [2*LW-1:0] rad_reg  [LW+1];

    // Stage zero is the unregistered input.
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign rad_reg[0]  = radicand;

    for (genvar i = 0; i < LW; i++) begin : g_stage
        logic [RW-1:0] rem_shift;
        logic [RW-1:0] trial;
        logic          take;

        // Bring down two radicand bits and try appending a one to the root.
        always_comb
        begin
            rem_shift = {rem_reg[i][RW-3:0], rad_reg[i][2*LW-1 -: 2]};
            trial     = {root_reg[i], 2'b01};
            take      = (rem_shift >= trial);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= take ? (rem_shift - trial) : rem_shift;
            root_reg[i+1] <= {root_reg[i][LW-2:0], take};
            rad_reg[i+1]  <= {rad_reg[i][2*LW-3:0], 2'b00};
        end
    end

    assign root = root_reg[LW];

endmodule

/* src/ssc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module ssc_div #(
    parameter int NW = 2 * ssc_pkg::COORD_BITS_DEF + 2,
    parameter int DW = ssc_pkg::COORD_BITS_DEF + 3,
    parameter int QW = ssc_pkg::COORD_BITS_DEF - 1
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quot
);

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];

    // The quotient fits in QW bits, so the upper numerator bits start below the divisor.
    assign rem_reg[0] = DW'(num >> QW);
    assign q_reg[0]   = '0;
    assign low_reg[0] = num[QW-1:0];
    assign den_reg[0] = den;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW:0] rem_shift;
        logic        take;

        always_comb
        begin
            rem_shift = {rem_reg[i], low_reg[i][QW-1]};
            take      = (rem_shift >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= take ? DW'(rem_shift - {1'b0, den_reg[i]}) : rem_shift[DW-1:0];
            q_reg[i+1]   <= {q_reg[i][QW-2:0], take};
            low_reg[i+1] <= {low_reg[i][QW-2:0], 1'b0};
            den_reg[i+1] <= den_reg[i];
        end
    end

    assign quot = q_reg[QW];

endmodule
